[hw/rtl/pic_pkg.sv]
// Shared constants and control/status types for the point-in-convex-polygon block.
package pic_pkg;

    localparam int MAX_VERTICES   = 16;
    localparam int COORD_BITS     = 16;
    localparam int MIN_POLY_VERTS = 3;

    localparam int IDX_BITS   = $clog2(MAX_VERTICES);
    localparam int CNT_BITS   = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                start;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        logic                rd_en;
        logic                rd_first;
        logic [IDX_BITS-1:0] rd_addr;
        logic                wrap;
    } pic_cmd_t;

    typedef struct packed {
        logic busy;
        logic mismatch;
    } pic_sts_t;

endpackage

[hw/rtl/pic_dp.sv]
// Datapath: vertex memory, edge and offset vectors, cross products and sign tracking.
module pic_dp
    import pic_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pic_cmd_t                     cmd,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output pic_sts_t                     sts
);

    logic signed [COORD_BITS-1:0] vtx_x_mem [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vtx_y_mem [MAX_VERTICES];

    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;

    logic s1_valid_reg, s1_first_reg, s1_wrap_reg;
    logic s2_valid_reg, s3_valid_reg;

    logic signed [DIFF_BITS-1:0] ex_reg, ey_reg, dx_reg, dy_reg;
    logic signed [DIFF_BITS-1:0] ex_next, ey_next, dx_next, dy_next;
    logic signed [PROD_BITS-1:0] prod_a_reg, prod_b_reg;
    logic signed [CROSS_BITS-1:0] cross_val;

    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic edge_valid;
    logic cross_nz, cross_neg;

    logic dir_set_reg, dir_set_next;
    logic dir_neg_reg, dir_neg_next;
    logic mismatch_reg, mismatch_next;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            vtx_x_mem[cmd.wr_addr] <= coord_x;
            vtx_y_mem[cmd.wr_addr] <= coord_y;
        end
        if (cmd.rd_en) begin
            rd_x_reg <= vtx_x_mem[cmd.rd_addr];
            rd_y_reg <= vtx_y_mem[cmd.rd_addr];
        end
    end

    always_comb begin
        cur_x      = s1_wrap_reg ? first_x_reg : rd_x_reg;
        cur_y      = s1_wrap_reg ? first_y_reg : rd_y_reg;
        edge_valid = s1_valid_reg && !s1_first_reg;
        ex_next    = {cur_x[COORD_BITS-1], cur_x} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        ey_next    = {cur_y[COORD_BITS-1], cur_y} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        dx_next    = {px_reg[COORD_BITS-1], px_reg} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        dy_next    = {py_reg[COORD_BITS-1], py_reg} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (s1_valid_reg && !s1_wrap_reg) begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        if (s1_valid_reg && s1_first_reg) begin
            first_x_reg <= rd_x_reg;
            first_y_reg <= rd_y_reg;
        end
        if (edge_valid) begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (s2_valid_reg) begin
            prod_a_reg <= PROD_BITS'(ex_reg) * PROD_BITS'(dy_reg);
            prod_b_reg <= PROD_BITS'(ey_reg) * PROD_BITS'(dx_reg);
        end
    end

    always_comb begin
        cross_val = {prod_a_reg[PROD_BITS-1], prod_a_reg}
                  - {prod_b_reg[PROD_BITS-1], prod_b_reg};
        cross_nz  = |cross_val;
        cross_neg = cross_val[CROSS_BITS-1];

        dir_set_next  = dir_set_reg;
        dir_neg_next  = dir_neg_reg;
        mismatch_next = mismatch_reg;
        if (cmd.start) begin
            dir_set_next  = 1'b0;
            dir_neg_next  = 1'b0;
            mismatch_next = 1'b0;
        end else if (s3_valid_reg && cross_nz) begin
            if (!dir_set_reg) begin
                dir_set_next = 1'b1;
                dir_neg_next = cross_neg;
            end else if (cross_neg != dir_neg_reg) begin
                mismatch_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_wrap_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            dir_set_reg  <= 1'b0;
            dir_neg_reg  <= 1'b0;
            mismatch_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.rd_en || cmd.wrap;
            s1_first_reg <= cmd.rd_en && cmd.rd_first;
            s1_wrap_reg  <= cmd.wrap;
            s2_valid_reg <= edge_valid;
            s3_valid_reg <= s2_valid_reg;
            dir_set_reg  <= dir_set_next;
            dir_neg_reg  <= dir_neg_next;
            mismatch_reg <= mismatch_next;
        end
    end

    assign sts.busy     = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign sts.mismatch = mismatch_reg;

endmodule

[hw/rtl/pic_ctrl.sv]
// Controller: handshakes, vertex count register, edge walk sequencing and result register.
module pic_ctrl
    import pic_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CNT_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [IDX_BITS-1:0] s_vertex_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_inside_res,
    output pic_cmd_t            cmd,
    input  pic_sts_t            sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_WRAP   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] vertex_count_reg, vertex_count_next;
    logic                short_reg, short_next;
    logic                m_valid_reg, m_valid_next;
    logic                inside_reg, inside_next;

    logic [CNT_BITS-1:0] eff_n, eff_n_m1;
    logic [IDX_BITS-1:0] last_idx;

    always_comb begin
        eff_n    = (vertex_count_reg > CNT_BITS'(MAX_VERTICES)) ?
                   CNT_BITS'(MAX_VERTICES) : vertex_count_reg;
        eff_n_m1 = eff_n - CNT_BITS'(1);
        last_idx = eff_n_m1[IDX_BITS-1:0];
    end

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        short_next        = short_reg;
        vertex_count_next = cfg_wr_en ? cfg_wr_data : vertex_count_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        inside_next       = inside_reg;
        s_ready           = (state_reg == ST_IDLE);

        cmd          = '0;
        cmd.wr_addr  = s_vertex_slot;
        cmd.rd_addr  = idx_reg;
        cmd.rd_first = (idx_reg == '0);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_QUERY) begin
                        cmd.start = 1'b1;
                        idx_next  = '0;
                        if (eff_n < CNT_BITS'(MIN_POLY_VERTS)) begin
                            short_next = 1'b1;
                            state_next = ST_RESULT;
                        end else begin
                            short_next = 1'b0;
                            state_next = ST_READ;
                        end
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                if (idx_reg == last_idx) begin
                    state_next = ST_WRAP;
                end else begin
                    idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    inside_next  = !short_reg && !sts.mismatch;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            short_reg        <= 1'b0;
            vertex_count_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            short_reg        <= short_next;
            vertex_count_reg <= vertex_count_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inside_reg <= inside_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;

endmodule

[hw/rtl/point_in_convex_polygon.sv]
// Top level of the point-in-convex-polygon test: controller plus datapath.
//
// The input channel (s_valid/s_ready) takes one beat per item. A beat with
// s_action = 0 writes coordinates into slot s_vertex_slot of the vertex table
// and gives no result. A beat with s_action = 1 queries the point and gives
// exactly one result beat on the m_ channel.
// A query with n vertices in use (vertex_count, clamped to 16) reads one vertex
// per cycle from the vertex memory through a single shared cross-product unit,
// or goes straight to a result of outside when n is below three. The next beat
// is accepted once the controller is back in idle, after the query's result
// has been placed in the output register.
// The result sits in an output register; while the receiver stalls, loads are
// still taken and a finished query waits until the register is free.
// vertex_count is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// Reset clears vertex_count and all handshake state; the vertex table is not
// cleared, and every slot below vertex_count must be loaded before a query.
module point_in_convex_polygon
    import pic_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CNT_BITS-1:0]          cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic [IDX_BITS-1:0]          s_vertex_slot,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_inside_res
);

    pic_cmd_t cmd;
    pic_sts_t sts;

    pic_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_vertex_slot (s_vertex_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .cmd           (cmd),
        .sts           (sts)
    );

    pic_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .coord_x (s_coord_x),
        .coord_y (s_coord_y),
        .sts     (sts)
    );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the point-in-convex-polygon block.
`timescale 1ns / 100ps

module testbench
    import pic_pkg::*;
();

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 800;
    localparam int REPORT_LIMIT   = 10;
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
    localparam int COUNT_ALL_ONES = (1 << CNT_BITS) - 1;
    localparam int CIRCLE_POINTS  = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    class inside_scoreboard;
        coord_t      vert_x [MAX_VERTICES];
        coord_t      vert_y [MAX_VERTICES];
        int unsigned vertex_count;
        bit          expected_inside [$];
        int unsigned errors;

        function new();
            vertex_count = 0;
            errors = 0;
        endfunction

        function void set_vertex_count(int unsigned value);
            vertex_count = value;
        endfunction

        function bit predict_inside(coord_t px, coord_t py);
            int unsigned                   n;
            int unsigned                   j;
            int                            dir;
            logic signed [DIFF_BITS-1:0]   ex;
            logic signed [DIFF_BITS-1:0]   ey;
            logic signed [DIFF_BITS-1:0]   dx;
            logic signed [DIFF_BITS-1:0]   dy;
            logic signed [CROSS_BITS-1:0]  cr;
            n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
            if (n < MIN_POLY_VERTS) begin
                return 1'b0;
            end
            dir = 0;
            for (int unsigned i = 0; i < n; i++) begin
                j = (i + 1 == n) ? 0 : i + 1;
                ex = DIFF_BITS'(vert_x[j]) - DIFF_BITS'(vert_x[i]);
                ey = DIFF_BITS'(vert_y[j]) - DIFF_BITS'(vert_y[i]);
                dx = DIFF_BITS'(px) - DIFF_BITS'(vert_x[i]);
                dy = DIFF_BITS'(py) - DIFF_BITS'(vert_y[i]);
                cr = CROSS_BITS'(ex) * CROSS_BITS'(dy) - CROSS_BITS'(ey) * CROSS_BITS'(dx);
                if (cr != 0) begin
                    if (dir == 0) begin
                        dir = (cr > 0) ? 1 : -1;
                    end else if ((cr > 0) != (dir > 0)) begin
                        return 1'b0;
                    end
                end
            end
            return 1'b1;
        endfunction

        function void note_input(logic act, logic [IDX_BITS-1:0] slot, coord_t x, coord_t y);
            if (act == ACT_LOAD) begin
                vert_x[slot] = x;
                vert_y[slot] = y;
            end else begin
                expected_inside.insert(expected_inside.size(), predict_inside(x, y));
            end
        endfunction

        function void check_result(logic got);
            bit want;
            if (expected_inside.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected result beat: inside_res=%b", got);
                end
                return;
            end
            want = expected_inside.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("inside_res mismatch: expected %0b, got %b", want, got);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_inside.size();
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CNT_BITS-1:0]   cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_action      = ACT_LOAD;
    logic [IDX_BITS-1:0]   s_vertex_slot = '0;
    coord_t                s_coord_x     = '0;
    coord_t                s_coord_y     = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_inside_res;

    int                    sender_idle_pct = 0;
    int                    recv_stall_pct  = 0;
    inside_scoreboard      scoreboard;

    point_in_convex_polygon DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_vertex_slot (s_vertex_slot),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            scoreboard.note_input(s_action, s_vertex_slot, s_coord_x, s_coord_y);
        end
        if (aresetn && m_valid && m_ready) begin
            scoreboard.check_result(m_inside_res);
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic coord_t clamp_coord(int v);
        if (v > COORD_MAX) begin
            return coord_t'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

    // Cosine of k * 22.5 degrees, scaled by 1000.
    function automatic int circle_cos(int k);
        case (k % CIRCLE_POINTS)
            0:       return 1000;
            1, 15:   return 924;
            2, 14:   return 707;
            3, 13:   return 383;
            5, 11:   return -383;
            6, 10:   return -707;
            7, 9:    return -924;
            8:       return -1000;
            default: return 0;
        endcase
    endfunction

    task automatic send_beat(input logic act, input logic [IDX_BITS-1:0] slot,
                             input coord_t x, input coord_t y);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_vertex_slot <= slot;
        s_coord_x     <= x;
        s_coord_y     <= y;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (scoreboard.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_vertex_count(input int unsigned value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CNT_BITS-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        scoreboard.set_vertex_count(value);
    endtask

    initial begin
        int unsigned done_items;
        int unsigned phase;
        int unsigned n;
        int unsigned eff;
        int unsigned items;
        int unsigned pick;
        int unsigned roll;
        int unsigned need;
        int unsigned sel;
        int unsigned rot;
        int unsigned idx;
        int          picked [MAX_VERTICES];
        bit          reverse;
        bit          collinear;
        int          scale;
        int          lim;
        int          ctr_x;
        int          ctr_y;
        int          span;
        int          step_x;
        int          step_y;
        coord_t      poly_x [MAX_VERTICES];
        coord_t      poly_y [MAX_VERTICES];

        scoreboard = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        set_vertex_count(0);
        send_beat(ACT_QUERY, 0, coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        send_beat(ACT_LOAD, 0, -100, -100);
        send_beat(ACT_LOAD, 1, 100, -100);
        send_beat(ACT_LOAD, 2, 100, 100);
        send_beat(ACT_LOAD, 3, -100, 100);
        set_vertex_count(2);
        send_beat(ACT_QUERY, 0, 0, 0);
        set_vertex_count(4);
        send_beat(ACT_QUERY, 5, 0, 0);
        send_beat(ACT_QUERY, 10, 200, 0);
        send_beat(ACT_QUERY, 15, 100, 0);
        send_beat(ACT_QUERY, 0, 100, 100);
        send_beat(ACT_QUERY, 0, coord_t'(COORD_MAX), coord_t'(COORD_MIN));
        send_beat(ACT_LOAD, 0, 0, 0);
        send_beat(ACT_LOAD, 1, 1, 1);
        send_beat(ACT_LOAD, 2, 2, 2);
        set_vertex_count(3);
        send_beat(ACT_QUERY, 0, 5, 5);
        send_beat(ACT_QUERY, 0, 5, 6);
        send_beat(ACT_QUERY, 0, coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        send_beat(ACT_LOAD, 0, coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        send_beat(ACT_LOAD, 1, coord_t'(COORD_MAX), coord_t'(COORD_MIN));
        send_beat(ACT_LOAD, 2, coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        send_beat(ACT_QUERY, 0, 0, 0);
        send_beat(ACT_QUERY, 0, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        send_beat(ACT_QUERY, 0, coord_t'(COORD_MIN), coord_t'(COORD_MIN));

        done_items = 0;
        phase = 0;
        while (done_items < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            pick = $urandom_range(19);
            if (phase == 0) begin
                n = COUNT_ALL_ONES;
            end else if (phase == 1 || pick == 1) begin
                n = MAX_VERTICES;
            end else if (pick == 0) begin
                n = $urandom_range(MIN_POLY_VERTS - 1);
            end else if (pick == 2) begin
                n = $urandom_range(COUNT_ALL_ONES, MAX_VERTICES + 1);
            end else if (pick == 3) begin
                n = $urandom_range(MAX_VERTICES - 1, 9);
            end else begin
                n = $urandom_range(8, MIN_POLY_VERTS);
            end
            set_vertex_count(n);
            eff = (n > MAX_VERTICES) ? MAX_VERTICES : n;

            if (eff >= MIN_POLY_VERTS) begin
                collinear = ($urandom_range(9) == 0);
                if (collinear) begin
                    ctr_x  = int'($urandom_range(60000)) - 30000;
                    ctr_y  = int'($urandom_range(60000)) - 30000;
                    step_x = int'($urandom_range(100)) - 50;
                    step_y = int'($urandom_range(100)) - 50;
                    span   = 800;
                    for (int s = 0; s < eff; s++) begin
                        poly_x[s] = clamp_coord(ctr_x + s * step_x);
                        poly_y[s] = clamp_coord(ctr_y + s * step_y);
                    end
                end else begin
                    need = eff;
                    sel  = 0;
                    for (int k = 0; k < CIRCLE_POINTS; k++) begin
                        if (need > 0 && $urandom_range(CIRCLE_POINTS - 1 - k) < need) begin
                            picked[sel] = k;
                            sel++;
                            need--;
                        end
                    end
                    reverse = 1'($urandom_range(1));
                    rot     = $urandom_range(eff - 1);
                    scale   = $urandom_range(32, 1);
                    lim     = COORD_MAX - 1000 * scale;
                    ctr_x   = int'($urandom_range(2 * lim)) - lim;
                    ctr_y   = int'($urandom_range(2 * lim)) - lim;
                    span    = 1100 * scale;
                    for (int s = 0; s < eff; s++) begin
                        idx = reverse ? (eff - 1 - s) : s;
                        idx = (idx + rot) % eff;
                        poly_x[s] = clamp_coord(ctr_x + circle_cos(picked[idx]) * scale);
                        poly_y[s] = clamp_coord(ctr_y + circle_cos(picked[idx] + 12) * scale);
                    end
                end
                for (int s = 0; s < eff; s++) begin
                    send_beat(ACT_LOAD, s[IDX_BITS-1:0], poly_x[s], poly_y[s]);
                end
                done_items += eff;
            end

            items = $urandom_range(24, 8);
            repeat (items) begin
                roll = $urandom_range(99);
                if (roll < 20) begin
                    send_beat(ACT_LOAD, IDX_BITS'($urandom_range(MAX_VERTICES - 1)),
                              coord_t'($urandom()), coord_t'($urandom()));
                end else if (roll < 35 || eff < MIN_POLY_VERTS) begin
                    send_beat(ACT_QUERY, IDX_BITS'($urandom_range(MAX_VERTICES - 1)),
                              coord_t'($urandom()), coord_t'($urandom()));
                end else if (roll < 45) begin
                    idx = $urandom_range(eff - 1);
                    send_beat(ACT_QUERY, IDX_BITS'($urandom_range(MAX_VERTICES - 1)),
                              poly_x[idx], poly_y[idx]);
                end else begin
                    send_beat(ACT_QUERY, IDX_BITS'($urandom_range(MAX_VERTICES - 1)),
                              clamp_coord(ctr_x + int'($urandom_range(2 * span)) - span),
                              clamp_coord(ctr_y + int'($urandom_range(2 * span)) - span));
                end
            end
            done_items += items;
            phase++;
        end

        drain();
        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[point_in_convex_polygon.f]
hw/rtl/pic_pkg.sv
hw/rtl/pic_dp.sv
hw/rtl/pic_ctrl.sv
hw/rtl/point_in_convex_polygon.sv
verif/testbench.sv
